/* design/q16_pkg.sv */
// Shared types and constants for the Q16.16 function unit.
package q16_pkg;
    localparam int OpW   = 3;
    localparam int WordW = 32;
    localparam int InW   = OpW + 2 * WordW;
    localparam int OutW  = WordW + 1;

    localparam logic [OpW-1:0] OP_MUL   = 3'd0;
    localparam logic [OpW-1:0] OP_DIV   = 3'd1;
    localparam logic [OpW-1:0] OP_SQRT  = 3'd2;
    localparam logic [OpW-1:0] OP_ATAN2 = 3'd3;
    localparam logic [OpW-1:0] OP_ATAN  = 3'd4;
    localparam logic [OpW-1:0] OP_ASIN  = 3'd5;

    localparam logic [WordW-1:0] Q_ONE       = 32'h0001_0000;
    localparam logic [WordW-1:0] Q_PI_4      = 32'h0000_C90F;
    localparam logic [WordW-1:0] Q_3PI_4     = 32'h0002_5B2F;
    localparam logic [WordW-1:0] Q_CUBE_COEF = 32'h0000_3240;
    localparam logic [WordW-1:0] Q_LIN_COEF  = 32'h0000_FB50;
    localparam logic [WordW-1:0] Q_SQRT_HIGH = 32'hFFF0_0000;
    localparam logic [WordW-1:0] Q_HALF      = 32'h0000_8000;
    localparam logic [WordW-1:0] Q_FRAC_MAX  = 32'd65535;

    typedef struct packed {
        logic [OpW-1:0]   operation;
        logic [WordW-1:0] operand_a;
        logic [WordW-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [WordW-1:0] result;
        logic             divide_by_zero;
    } t_out_item;
endpackage

/* design/q16_chan_if.sv */
// Valid/ready channel interface carrying a packed payload.
interface q16_chan_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/q16_mul.sv */
// Two-stage Q16.16 multiplier: signed product, then truncating scale by 2^-16.
module q16_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic signed [63:0] r_prod;
    logic               r_v1;
    logic               r_done;
    logic [31:0]        r_q;
    logic signed [63:0] w_sum;

    // bias negative products so the shift truncates toward zero
    assign w_sum = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
        r_prod <= $signed(i_a) * $signed(i_b);
        r_q    <= w_sum[47:16];
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

/* design/q16_div.sv */
// Restoring divider: (a * 2^16) / b, one quotient bit per cycle, zero divisor saturates.
module q16_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q,
    output logic        o_dz
);
    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic        r_neg;
    logic [31:0] r_res;
    logic        r_dz;
    logic [31:0] w_am;
    logic [31:0] w_bm;
    logic [32:0] w_sh;
    logic [33:0] w_sub;
    logic        w_ge;

    assign w_am  = i_a[31] ? (32'd0 - i_a) : i_a;
    assign w_bm  = i_b[31] ? (32'd0 - i_b) : i_b;
    assign w_sh  = {r_rem, r_q[47]};
    assign w_sub = {1'b0, w_sh} - {2'b00, r_d};
    assign w_ge  = !w_sub[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_b == 32'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= {w_am, 16'd0};
            r_rem <= 32'd0;
            r_d   <= w_bm;
            r_neg <= i_a[31] ^ i_b[31];
            r_cnt <= 6'd48;
            r_dz  <= (i_b == 32'd0);
            r_res <= i_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_run) begin
            r_rem <= w_ge ? w_sub[31:0] : w_sh[31:0];
            r_q   <= {r_q[46:0], w_ge};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // quotient is taken from the shift register once the last bit has landed
    assign o_done = r_done;
    assign o_dz   = r_dz;
    assign o_q    = r_dz ? r_res : (r_neg ? (32'd0 - r_q[31:0]) : r_q[31:0]);
endmodule

/* design/q16_sqrt.sv */
// Bit-pair square root in two passes, one bit pair per cycle.
module q16_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_v,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic        r_align;
    logic        r_iter;
    logic        r_done;
    logic        r_pass;
    logic        r_neg;
    logic [31:0] r_num;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic [31:0] w_mag;
    logic [31:0] w_sum;
    logic [31:0] w_adj;

    assign w_mag = i_v[31] ? (32'd0 - i_v) : i_v;
    assign w_sum = r_root + r_bit;
    assign w_adj = r_num - r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= 1'b0;
            r_iter  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_align <= 1'b1;
            end else if (r_align) begin
                if (!(r_bit > r_num)) begin
                    r_align <= 1'b0;
                    r_iter  <= 1'b1;
                end
            end else if (r_iter) begin
                if (r_bit == 32'd0 && r_pass) begin
                    r_iter <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_neg  <= i_v[31];
            r_num  <= w_mag;
            r_root <= 32'd0;
            r_pass <= 1'b0;
            r_bit  <= ((w_mag & q16_pkg::Q_SQRT_HIGH) != 32'd0) ? (32'd1 << 30)
                                                                 : (32'd1 << 18);
        end else if (r_align) begin
            if (r_bit > r_num) begin
                r_bit <= r_bit >> 2;
            end
        end else if (r_iter) begin
            if (r_bit != 32'd0) begin
                if (r_num >= w_sum) begin
                    r_num  <= r_num - w_sum;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end else if (!r_pass) begin
                // end of first pass: rescale for the low 8 root bits
                if (r_num > q16_pkg::Q_FRAC_MAX) begin
                    r_num  <= (w_adj << 16) - q16_pkg::Q_HALF;
                    r_root <= (r_root << 16) + q16_pkg::Q_HALF;
                end else begin
                    r_num  <= r_num << 16;
                    r_root <= r_root << 16;
                end
                r_bit  <= 32'd1 << 14;
                r_pass <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? (32'd0 - r_root) : r_root;
endmodule

/* design/q16_function_unit.sv */
// Top level of the Q16.16 function unit: operation sequencer over shared units.
//
// Input channel i_in carries one transaction of {operation, operand_a, operand_b};
// output channel o_out carries {result, divide_by_zero}. Both use valid/ready and a
// transaction moves on a clock edge where both are high.
// Operations: multiply, divide, square root, atan2, atan and arcsine. Codes 6 and 7
// and arcsine outside [-1, 1] return zero with the flag clear, going straight to output.
// One transaction is worked at a time; i_in.ready is high only while idle.
// Work per operation on the shared units: multiply one product; divide one quotient
//   bit per cycle over 48 bits (a zero divisor skips the loop); square root one bit
//   pair per cycle over two passes; atan2/atan one divide then four multiplies;
//   arcsine a multiply, a root, two divides and four multiplies.
// A stalled receiver holds the result in the output register; no new transaction
// is accepted until it is taken. Synchronous reset returns the sequencer to idle
// and drops any transaction in flight.
module q16_function_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    q16_chan_if.sink              i_in,
    q16_chan_if.source            o_out
);
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MUL   = 13'b0000000000010,
        ST_DIV   = 13'b0000000000100,
        ST_SQRT  = 13'b0000000001000,
        ST_ASQ   = 13'b0000000010000,
        ST_ASQRT = 13'b0000000100000,
        ST_ADIV  = 13'b0000001000000,
        ST_ATDIV = 13'b0000010000000,
        ST_R2    = 13'b0000100000000,
        ST_R3    = 13'b0001000000000,
        ST_M1    = 13'b0010000000000,
        ST_M2    = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic [2:0]          r_op;
    logic [31:0]         r_a;
    logic [31:0]         r_y;
    logic [31:0]         r_x;
    logic [31:0]         r_t;
    logic [31:0]         r_r;
    logic [31:0]         r_m1;
    logic [31:0]         r_res;
    logic                r_dz;
    q16_pkg::t_in_item   w_in;
    q16_pkg::t_out_item  w_out;

    logic        w_is_mul;
    logic        w_is_div;
    logic        w_is_sqrt;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_div_a;
    logic [31:0] w_div_b;
    logic [31:0] w_sqrt_v;
    logic        w_mul_done;
    logic        w_div_done;
    logic        w_sqrt_done;
    logic [31:0] w_mul_q;
    logic [31:0] w_div_q;
    logic [31:0] w_sqrt_q;
    logic        w_div_dz;
    logic [31:0] w_ay;
    logic [31:0] w_angle;
    logic        w_unit_done;

    assign w_in = i_in.data;

    assign w_is_mul  = (r_state == ST_MUL) || (r_state == ST_ASQ) || (r_state == ST_R2)
                    || (r_state == ST_R3) || (r_state == ST_M1) || (r_state == ST_M2);
    assign w_is_div  = (r_state == ST_DIV) || (r_state == ST_ADIV) || (r_state == ST_ATDIV);
    assign w_is_sqrt = (r_state == ST_SQRT) || (r_state == ST_ASQRT);

    assign w_ay = r_y[31] ? (32'd0 - r_y) : r_y;

    always_comb begin
        w_mul_a  = r_a;
        w_mul_b  = r_x;
        w_div_a  = r_a;
        w_div_b  = r_x;
        w_sqrt_v = r_a;
        unique case (r_state)
            ST_ASQ: begin
                w_mul_b = r_a;
            end
            ST_R2: begin
                w_mul_a = r_r;
                w_mul_b = r_r;
            end
            ST_R3: begin
                w_mul_a = r_t;
                w_mul_b = r_r;
            end
            ST_M1: begin
                w_mul_a = q16_pkg::Q_CUBE_COEF;
                w_mul_b = r_t;
            end
            ST_M2: begin
                w_mul_a = q16_pkg::Q_LIN_COEF;
                w_mul_b = r_r;
            end
            ST_ASQRT: begin
                w_sqrt_v = q16_pkg::Q_ONE - r_t;
            end
            ST_ADIV: begin
                w_div_b = r_t;
            end
            ST_ATDIV: begin
                if (!r_x[31]) begin
                    w_div_a = r_x - w_ay;
                    w_div_b = r_x + w_ay;
                end else begin
                    w_div_a = r_x + w_ay;
                    w_div_b = w_ay - r_x;
                end
            end
            default: begin
            end
        endcase
    end

    q16_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_mul && !r_busy),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_q     (w_mul_q)
    );

    q16_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_div && !r_busy),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_dz    (w_div_dz)
    );

    q16_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_sqrt && !r_busy),
        .i_v     (w_sqrt_v),
        .o_done  (w_sqrt_done),
        .o_q     (w_sqrt_q)
    );

    assign w_unit_done = (w_is_mul && w_mul_done) || (w_is_div && w_div_done)
                      || (w_is_sqrt && w_sqrt_done);

    assign w_angle = r_m1 - w_mul_q + (r_x[31] ? q16_pkg::Q_3PI_4 : q16_pkg::Q_PI_4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            if (r_state != ST_IDLE && r_state != ST_OUT) begin
                r_busy <= !w_unit_done;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_op <= w_in.operation;
                        r_a  <= w_in.operand_a;
                        r_y  <= w_in.operand_a;
                        r_x  <= (w_in.operation == q16_pkg::OP_ATAN) ? q16_pkg::Q_ONE
                                                                     : w_in.operand_b;
                        r_dz <= 1'b0;
                        case (w_in.operation)
                            q16_pkg::OP_MUL:   r_state <= ST_MUL;
                            q16_pkg::OP_DIV:   r_state <= ST_DIV;
                            q16_pkg::OP_SQRT:  r_state <= ST_SQRT;
                            q16_pkg::OP_ATAN2: r_state <= ST_ATDIV;
                            q16_pkg::OP_ATAN:  r_state <= ST_ATDIV;
                            q16_pkg::OP_ASIN: begin
                                if ($signed(w_in.operand_a) > $signed(q16_pkg::Q_ONE)
                                 || $signed(w_in.operand_a) < -$signed(q16_pkg::Q_ONE)) begin
                                    r_res   <= 32'd0;
                                    r_state <= ST_OUT;
                                end else begin
                                    r_state <= ST_ASQ;
                                end
                            end
                            default: begin
                                r_res   <= 32'd0;
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_MUL: if (w_mul_done) begin
                    r_res   <= w_mul_q;
                    r_state <= ST_OUT;
                end
                ST_DIV: if (w_div_done) begin
                    r_res   <= w_div_q;
                    r_dz    <= w_div_dz;
                    r_state <= ST_OUT;
                end
                ST_SQRT: if (w_sqrt_done) begin
                    r_res   <= w_sqrt_q;
                    r_state <= ST_OUT;
                end
                ST_ASQ: if (w_mul_done) begin
                    r_t     <= w_mul_q;
                    r_state <= ST_ASQRT;
                end
                ST_ASQRT: if (w_sqrt_done) begin
                    r_t     <= w_sqrt_q;
                    r_state <= ST_ADIV;
                end
                ST_ADIV: if (w_div_done) begin
                    // the quotient becomes y of atan2(y, one)
                    r_y     <= w_div_q;
                    r_x     <= q16_pkg::Q_ONE;
                    r_dz    <= r_dz | w_div_dz;
                    r_state <= ST_ATDIV;
                end
                ST_ATDIV: if (w_div_done) begin
                    r_r     <= w_div_q;
                    r_dz    <= r_dz | w_div_dz;
                    r_state <= ST_R2;
                end
                ST_R2: if (w_mul_done) begin
                    r_t     <= w_mul_q;
                    r_state <= ST_R3;
                end
                ST_R3: if (w_mul_done) begin
                    r_t     <= w_mul_q;
                    r_state <= ST_M1;
                end
                ST_M1: if (w_mul_done) begin
                    r_m1    <= w_mul_q;
                    r_state <= ST_M2;
                end
                ST_M2: if (w_mul_done) begin
                    r_res   <= r_y[31] ? (32'd0 - w_angle) : w_angle;
                    r_state <= ST_OUT;
                end
                ST_OUT: if (o_out.ready) begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign w_out.result         = r_res;
    assign w_out.divide_by_zero = r_dz;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data  = w_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    a_dz_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_dz) |-> (r_op == q16_pkg::OP_DIV || r_op == q16_pkg::OP_ATAN2
                                || r_op == q16_pkg::OP_ATAN || r_op == q16_pkg::OP_ASIN))
        else $error("divide-by-zero flag on an operation without division");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_is_mul, w_is_div, w_is_sqrt}) <= 1)
        else $error("more than one shared unit selected");

    a_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("accepted a transaction without leaving idle");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Q16.16 function unit.
module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    q16_chan_if #(.W(q16_pkg::InW))  in_ch ();
    q16_chan_if #(.W(q16_pkg::OutW)) out_ch ();

    q16_function_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    localparam int IdleLimit = 20000;
    localparam int NumRandom = 700;
    localparam logic [q16_pkg::WordW-1:0] MIN_WORD = 32'h8000_0000;
    localparam logic [q16_pkg::WordW-1:0] MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [q16_pkg::OpW-1:0]   OP_UNUSED6 = 3'd6;
    localparam logic [q16_pkg::OpW-1:0]   OP_UNUSED7 = 3'd7;

    q16_pkg::t_out_item expected_results[$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    int        idle_cycles = 0;
    int        results_seen = 0;
    bit        long_hold = 1'b0;

    // ---------------- predictor ----------------
    function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        p = p / 64'sd65536;
        return p[31:0];
    endfunction

    function automatic logic [31:0] fx_div(logic [31:0] a, logic [31:0] b, ref bit dz);
        logic signed [63:0] n;
        logic signed [63:0] q;
        n = $signed(a) * 64'sd65536;
        if (b == 0) begin
            dz = 1'b1;
            return a[31] ? MIN_WORD : MAX_WORD;
        end
        q = n / $signed({{32{b[31]}}, b});
        return q[31:0];
    endfunction

    function automatic logic [31:0] fx_atan2(logic [31:0] y, logic [31:0] x, ref bit dz);
        logic [31:0] ay, r, r3, base, ang;
        ay = y[31] ? -y : y;
        if (!x[31]) begin
            r = fx_div(x - ay, x + ay, dz);
            base = q16_pkg::Q_PI_4;
        end else begin
            r = fx_div(x + ay, ay - x, dz);
            base = q16_pkg::Q_3PI_4;
        end
        r3 = fx_mul(fx_mul(r, r), r);
        ang = fx_mul(q16_pkg::Q_CUBE_COEF, r3) - fx_mul(q16_pkg::Q_LIN_COEF, r) + base;
        return y[31] ? -ang : ang;
    endfunction

    function automatic logic [31:0] fx_sqrt(logic [31:0] v);
        logic [31:0] num, root, bits;
        bit neg;
        neg = v[31];
        num = neg ? -v : v;
        root = 0;
        bits = (num & q16_pkg::Q_SQRT_HIGH) != 0 ? 32'h4000_0000 : 32'h0004_0000;
        while (bits > num) bits = bits >> 2;
        for (int pass = 0; pass < 2; pass++) begin
            while (bits != 0) begin
                if (num >= root + bits) begin
                    num = num - (root + bits);
                    root = (root >> 1) + bits;
                end else begin
                    root = root >> 1;
                end
                bits = bits >> 2;
            end
            if (pass == 0) begin
                if (num > q16_pkg::Q_FRAC_MAX) begin
                    num = num - root;
                    num = (num << 16) - q16_pkg::Q_HALF;
                    root = (root << 16) + q16_pkg::Q_HALF;
                end else begin
                    num = num << 16;
                    root = root << 16;
                end
                bits = 32'h0000_4000;
            end
        end
        return neg ? -root : root;
    endfunction

    function automatic q16_pkg::t_out_item predict_math(q16_pkg::t_in_item it);
        q16_pkg::t_out_item o;
        bit dz;
        logic [31:0] t;
        dz = 1'b0;
        o.result = '0;
        case (it.operation)
            q16_pkg::OP_MUL:   o.result = fx_mul(it.operand_a, it.operand_b);
            q16_pkg::OP_DIV:   o.result = fx_div(it.operand_a, it.operand_b, dz);
            q16_pkg::OP_SQRT:  o.result = fx_sqrt(it.operand_a);
            q16_pkg::OP_ATAN2: o.result = fx_atan2(it.operand_a, it.operand_b, dz);
            q16_pkg::OP_ATAN:  o.result = fx_atan2(it.operand_a, q16_pkg::Q_ONE, dz);
            q16_pkg::OP_ASIN: begin
                if ($signed(it.operand_a) > 32'sd65536 || $signed(it.operand_a) < -32'sd65536)
                    o.result = '0;
                else begin
                    t = q16_pkg::Q_ONE - fx_mul(it.operand_a, it.operand_a);
                    t = fx_div(it.operand_a, fx_sqrt(t), dz);
                    o.result = fx_atan2(t, q16_pkg::Q_ONE, dz);
                end
            end
            default:  o.result = '0;
        endcase
        o.divide_by_zero = dz;
        return o;
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        logic [q16_pkg::OpW-1:0]   op;
        logic [q16_pkg::WordW-1:0] a;
        logic [q16_pkg::WordW-1:0] b;
        bit                        known;
        logic [q16_pkg::WordW-1:0] res;
        bit                        dz;
    } t_row;

    t_row directed[] = '{
        '{q16_pkg::OP_MUL,   q16_pkg::Q_ONE, q16_pkg::Q_ONE, 1, q16_pkg::Q_ONE, 0},
        '{q16_pkg::OP_MUL,   MAX_WORD, MAX_WORD, 0, 0,        0},
        '{q16_pkg::OP_MUL,   MIN_WORD, MIN_WORD, 0, 0,        0},
        '{q16_pkg::OP_MUL,   32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0, 0},
        '{q16_pkg::OP_DIV,   q16_pkg::Q_ONE, q16_pkg::Q_ONE, 1, q16_pkg::Q_ONE, 0},
        '{q16_pkg::OP_DIV,   32'h0,    32'h0,    1, MAX_WORD, 1},
        '{q16_pkg::OP_DIV,   MIN_WORD, 32'h0,    1, MIN_WORD, 1},
        '{q16_pkg::OP_DIV,   MAX_WORD, 32'h0,    1, MAX_WORD, 1},
        '{q16_pkg::OP_DIV,   MIN_WORD, 32'hFFFF_FFFF, 0, 0,   0},
        '{q16_pkg::OP_SQRT,  32'h0,    32'h0,    1, 32'h0,    0},
        '{q16_pkg::OP_SQRT,  q16_pkg::Q_ONE, 32'h0, 1, q16_pkg::Q_ONE, 0},
        '{q16_pkg::OP_SQRT,  MAX_WORD, 32'h0,    0, 0,        0},
        '{q16_pkg::OP_SQRT,  MIN_WORD, 32'h0,    0, 0,        0},
        '{q16_pkg::OP_SQRT,  32'hFFF0_0000, 32'h0, 0, 0,      0},
        '{q16_pkg::OP_ATAN2, 32'h0,    32'h0,    0, 0,        0},
        '{q16_pkg::OP_ATAN2, MIN_WORD, q16_pkg::Q_ONE, 0, 0,  0},
        '{q16_pkg::OP_ATAN2, q16_pkg::Q_ONE, MIN_WORD, 0, 0,  0},
        '{q16_pkg::OP_ATAN2, MAX_WORD, MAX_WORD, 0, 0,        0},
        '{q16_pkg::OP_ATAN,  q16_pkg::Q_ONE, 32'h0, 0, 0,     0},
        '{q16_pkg::OP_ATAN,  MIN_WORD, 32'h0,    0, 0,        0},
        '{q16_pkg::OP_ASIN,  q16_pkg::Q_ONE, 32'h0, 0, 0,     0},
        '{q16_pkg::OP_ASIN,  32'hFFFF_0000, 32'h0, 0, 0,      0},
        '{q16_pkg::OP_ASIN,  32'h0001_0001, 32'h0, 1, 32'h0,  0},
        '{OP_UNUSED6,        MAX_WORD, MAX_WORD, 1, 32'h0,    0},
        '{OP_UNUSED7,        MIN_WORD, MIN_WORD, 1, 32'h0,    0}
    };

    // ---------------- sender ----------------
    task automatic send_item(q16_pkg::t_in_item it, q16_pkg::t_out_item exp_item);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            // drop valid for the idle stretch
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        expected_results.push_back(exp_item);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 32'h0002_0000);
            2:       return -$urandom_range(0, 32'h0002_0000);
            3:       return {{16{1'b0}}, 16'($urandom())} | ($urandom_range(0, 1) ? MIN_WORD : 0);
            4:       return $urandom_range(0, 1) ? MAX_WORD : MIN_WORD;
            default: return $urandom_range(0, 32'h00FF_FFFF) << $urandom_range(0, 8);
        endcase
    endfunction

    initial begin
        q16_pkg::t_in_item  it;
        q16_pkg::t_out_item ex;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) begin
            it = '{directed[k].op, directed[k].a, directed[k].b};
            if (directed[k].known) ex = '{directed[k].res, directed[k].dz};
            else ex = predict_math(it);
            send_item(it, ex);
        end
        for (int n = 0; n < NumRandom; n++) begin
            it.operation = ($urandom_range(0, 19) == 0)
                         ? q16_pkg::OpW'($urandom_range(6, 7))
                         : q16_pkg::OpW'($urandom_range(0, 5));
            it.operand_a = random_word();
            it.operand_b = ($urandom_range(0, 15) == 0) ? 32'h0 : random_word();
            // keep most arcsine operands inside the domain
            if (it.operation == q16_pkg::OP_ASIN && $urandom_range(0, 3) != 0)
                it.operand_a = $urandom_range(0, 1) ? $urandom_range(0, 32'h0001_0000)
                                                    : -$urandom_range(0, 32'h0001_0000);
            send_item(it, predict_math(it));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------- receiver ----------------
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            // hold off once while the sender keeps offering transactions
            if (!long_hold && results_seen >= 100) begin
                long_hold = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0)
                out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                out_ch.ready <= $urandom_range(0, 1);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---------------- checker and watchdog ----------------
    always @(posedge i_clk) begin
        q16_pkg::t_out_item got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.result !== want.result) begin
                    $display("%0t: result expected %h actual %h", $time, want.result,
                             got.result);
                    errors++;
                end
                if (got.divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             want.divide_by_zero, got.divide_by_zero);
                    errors++;
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= IdleLimit) begin
                $display("testbench NOT OK");
                $finish;
            end
            if (stim_done && expected_results.size() == 0) begin
                repeat (200) @(posedge i_clk);
                if (errors == 0 && expected_results.size() == 0)
                    $display("testbench OK");
                else
                    $display("testbench NOT OK");
                $finish;
            end
        end
    end
endmodule
